[hdl/sfa_pkg.sv]
// Shared types and codes for the segment fit allocator.
`default_nettype none
package sfa_pkg;

  // One segment table entry: owner 0 marks a free segment
  typedef struct packed {
    logic [15:0] owner;
    logic [15:0] size;
  } seg_t;

  // Placement rules
  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  // Result codes
  localparam logic [2:0] ST_DONE     = 3'd0;
  localparam logic [2:0] ST_NOFIT    = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_BAD      = 3'd4;

  // Register indexes
  localparam logic [7:0] REG_STRATEGY = 8'd0;
  localparam logic [7:0] REG_TOTAL    = 8'd1;

  // Request kinds
  localparam logic MODE_ALLOC   = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  localparam logic [15:0] DEFAULT_TOTAL = 16'd4000;

endpackage
`default_nettype wire

[hdl/segment_fit_allocator.sv]
// Top level of the segment fit allocator: request sequencer around the table memory.
//
//  channel   direction  handshake               payload
//  request   in         start & !busy           mode, owner_id, request_size
//  result    out        done (one cycle pulse)  status
//  config    in         cfg_valid & cfg_ready   cfg_index, cfg_data
//
// An allocate scans the table, then for a split moves the entries behind the
// pick up by one and writes two entries; a release streams the table once,
// freeing and merging in the same pass. The result is then shown in the done
// state. After reset the init state writes the first entry; the receiver
// cannot stall and config is taken only while idle.
`default_nettype none
module segment_fit_allocator #(
  parameter int MAX_SEGMENTS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        mode,
  input  wire logic [15:0] owner_id,
  input  wire logic [15:0] request_size,
  output logic             done,
  output logic [2:0]       status,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import sfa_pkg::*;

  localparam int AW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_SEGMENTS);
  localparam logic [CW-1:0] CNT_ONE = CW'(1);

  typedef enum logic [7:0] {
    S_INIT   = 8'b00000001,
    S_IDLE   = 8'b00000010,
    S_SCAN   = 8'b00000100,
    S_SHIFT  = 8'b00001000,
    S_SPLITA = 8'b00010000,
    S_SPLITB = 8'b00100000,
    S_REL    = 8'b01000000,
    S_FIN    = 8'b10000000
  } state_t;

  state_t         state, state_next;
  logic [1:0]     strategy, strategy_next;
  logic [CW-1:0]  cnt, cnt_next;
  logic [CW-1:0]  rd_idx, rd_idx_next;
  logic           rd_vld, rd_vld_next;
  logic [AW-1:0]  rd_pos, rd_pos_next;
  logic           found, found_next;
  logic [AW-1:0]  pick, pick_next;
  logic [15:0]    pick_size, pick_size_next;
  logic [CW-1:0]  wr_ptr, wr_ptr_next;
  logic [15:0]    prev_owner, prev_owner_next;
  logic [15:0]    prev_size, prev_size_next;
  logic [15:0]    req_id, req_id_next;
  logic [15:0]    req_size, req_size_next;
  logic [2:0]     status_next;

  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  seg_t           mem_wdata;
  logic [AW-1:0]  mem_raddr;
  seg_t           mem_rdata;

  logic [CW-1:0]  pick_up;
  logic           take;
  logic [15:0]    cur_owner;
  logic [15:0]    sum;

  sfa_mem #(.DEPTH(MAX_SEGMENTS), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign busy      = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign done      = (state == S_FIN);
  assign pick_up   = CW'(pick) + CNT_ONE;

  // sequencer
  always_comb begin
    state_next      = state;
    strategy_next   = strategy;
    cnt_next        = cnt;
    rd_idx_next     = rd_idx;
    rd_vld_next     = 1'b0;
    rd_pos_next     = rd_pos;
    found_next      = found;
    pick_next       = pick;
    pick_size_next  = pick_size;
    wr_ptr_next     = wr_ptr;
    prev_owner_next = prev_owner;
    prev_size_next  = prev_size;
    req_id_next     = req_id;
    req_size_next   = req_size;
    status_next     = status;
    mem_we          = 1'b0;
    mem_waddr       = '0;
    mem_wdata       = '0;
    mem_raddr       = rd_idx[AW-1:0];
    take            = 1'b0;
    cur_owner       = mem_rdata.owner;
    sum             = prev_size + mem_rdata.size;

    case (state)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = '{owner: 16'd0, size: DEFAULT_TOTAL};
        state_next = S_IDLE;
      end

      S_IDLE: begin
        if (cfg_valid) begin
          if (cfg_index == REG_STRATEGY) begin
            strategy_next = cfg_data[1:0];
          end else if (cfg_index == REG_TOTAL) begin
            cnt_next  = CNT_ONE;
            mem_we    = 1'b1;
            mem_wdata = '{owner: 16'd0, size: cfg_data};
          end
        end
        if (start) begin
          req_id_next   = owner_id;
          req_size_next = request_size;
          rd_idx_next   = '0;
          found_next    = 1'b0;
          wr_ptr_next   = '0;
          if (owner_id == 16'd0 || (mode == MODE_ALLOC && request_size == 16'd0)) begin
            status_next = ST_BAD;
            state_next  = S_FIN;
          end else if (mode == MODE_RELEASE) begin
            state_next = S_REL;
          end else if (strategy != FIT_FIRST && strategy != FIT_BEST &&
                       strategy != FIT_WORST) begin
            status_next = ST_NOFIT;
            state_next  = S_FIN;
          end else begin
            state_next = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // issue reads in order, judge each entry in the cycle after its read
        if (rd_idx < cnt) begin
          rd_vld_next = 1'b1;
          rd_pos_next = rd_idx[AW-1:0];
          rd_idx_next = rd_idx + CNT_ONE;
        end
        if (rd_vld && mem_rdata.owner == 16'd0 && mem_rdata.size >= req_size) begin
          take = !found ||
                 (strategy == FIT_BEST  && mem_rdata.size < pick_size) ||
                 (strategy == FIT_WORST && mem_rdata.size > pick_size);
          if (take) begin
            found_next     = 1'b1;
            pick_next      = rd_pos;
            pick_size_next = mem_rdata.size;
          end
        end
        if (!(rd_idx < cnt) && !rd_vld) begin
          if (!found) begin
            status_next = ST_NOFIT;
            state_next  = S_FIN;
          end else if (pick_size == req_size) begin
            mem_we      = 1'b1;
            mem_waddr   = pick;
            mem_wdata   = '{owner: req_id, size: req_size};
            status_next = ST_DONE;
            state_next  = S_FIN;
          end else if (cnt >= CNT_MAX) begin
            status_next = ST_FULL;
            state_next  = S_FIN;
          end else begin
            rd_idx_next = cnt - CNT_ONE;
            state_next  = S_SHIFT;
          end
        end
      end

      S_SHIFT: begin
        // move entries behind the pick up by one, last first
        if (rd_idx >= pick_up) begin
          rd_vld_next = 1'b1;
          rd_pos_next = rd_idx[AW-1:0];
          rd_idx_next = rd_idx - CNT_ONE;
        end
        if (rd_vld) begin
          mem_we    = 1'b1;
          mem_waddr = rd_pos + AW'(1);
          mem_wdata = mem_rdata;
        end
        if (!(rd_idx >= pick_up) && !rd_vld) begin
          state_next = S_SPLITA;
        end
      end

      S_SPLITA: begin
        mem_we     = 1'b1;
        mem_waddr  = pick_up[AW-1:0];
        mem_wdata  = '{owner: 16'd0, size: pick_size - req_size};
        state_next = S_SPLITB;
      end

      S_SPLITB: begin
        mem_we      = 1'b1;
        mem_waddr   = pick;
        mem_wdata   = '{owner: req_id, size: req_size};
        cnt_next    = cnt + CNT_ONE;
        status_next = ST_DONE;
        state_next  = S_FIN;
      end

      S_REL: begin
        // free matching entries and compact free runs in one pass
        if (rd_idx < cnt) begin
          rd_vld_next = 1'b1;
          rd_pos_next = rd_idx[AW-1:0];
          rd_idx_next = rd_idx + CNT_ONE;
        end
        if (rd_vld) begin
          if (mem_rdata.owner == req_id) begin
            cur_owner  = 16'd0;
            found_next = 1'b1;
          end
          mem_we = 1'b1;
          if (wr_ptr != '0 && prev_owner == 16'd0 && cur_owner == 16'd0) begin
            mem_waddr      = wr_ptr[AW-1:0] - AW'(1);
            mem_wdata      = '{owner: 16'd0, size: sum};
            prev_size_next = sum;
          end else begin
            mem_waddr       = wr_ptr[AW-1:0];
            mem_wdata       = '{owner: cur_owner, size: mem_rdata.size};
            prev_owner_next = cur_owner;
            prev_size_next  = mem_rdata.size;
            wr_ptr_next     = wr_ptr + CNT_ONE;
          end
        end
        if (!(rd_idx < cnt) && !rd_vld) begin
          cnt_next    = wr_ptr;
          status_next = found ? ST_DONE : ST_NOTFOUND;
          state_next  = S_FIN;
        end
      end

      S_FIN: begin
        state_next = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      strategy <= FIT_FIRST;
      cnt      <= CNT_ONE;
      rd_vld   <= 1'b0;
    end else begin
      state    <= state_next;
      strategy <= strategy_next;
      cnt      <= cnt_next;
      rd_vld   <= rd_vld_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    rd_idx     <= rd_idx_next;
    rd_pos     <= rd_pos_next;
    found      <= found_next;
    pick       <= pick_next;
    pick_size  <= pick_size_next;
    wr_ptr     <= wr_ptr_next;
    prev_owner <= prev_owner_next;
    prev_size  <= prev_size_next;
    req_id     <= req_id_next;
    req_size   <= req_size_next;
    status     <= status_next;
  end

endmodule
`default_nettype wire

[hdl/sfa_mem.sv]
// Segment table memory: one write port, one read port, registered read data.
`default_nettype none
module sfa_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire                logic   clk,
  input  wire                logic   we,
  input  wire                logic [AW-1:0] waddr,
  input  wire                sfa_pkg::seg_t wdata,
  input  wire                logic [AW-1:0] raddr,
  output sfa_pkg::seg_t      rdata
);
  import sfa_pkg::*;

  seg_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[hdl/sfa_checker.sv]
// Port level checks for the segment fit allocator, bound to the top level.
`default_nettype none
module sfa_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       done,
  input wire logic [2:0] status,
  input wire logic       cfg_valid,
  input wire logic       cfg_ready
);
  import sfa_pkg::*;

  // an accepted item makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted item did not raise busy");

  // a result only ends a busy period
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("result outside a request");

  // after a result the block is free again
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy) else $error("block stayed busy after result");

  // only defined codes are reported
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == ST_DONE || status == ST_NOFIT || status == ST_FULL ||
              status == ST_NOTFOUND || status == ST_BAD))
    else $error("undefined status code");

  // configuration is taken only while idle
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |-> !busy) else $error("config taken while busy");

endmodule

bind segment_fit_allocator sfa_checker u_sfa_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .status    (status),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);
`default_nettype wire

[sim/segment_fit_allocator_tb.sv]
// Self-checking testbench for the segment fit allocator: queued driver, clocked monitor.
module segment_fit_allocator_tb;
  import sfa_pkg::*;

  localparam int NSEG = 64;

  typedef enum logic [1:0] {K_REQ, K_CFG, K_PAUSE} kind_t;

  typedef struct {
    kind_t       kind;
    logic        mode;
    logic [15:0] id;
    logic [15:0] size;
    logic [7:0]  idx;
    logic [15:0] data;
  } item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        mode = MODE_ALLOC;
  logic [15:0] owner_id = '0;
  logic [15:0] request_size = '0;
  logic        done;
  logic [2:0]  status;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  item_t       pending[$];
  logic [2:0]  status_due[$];
  logic        req_taken = 1'b0;
  logic        cfg_taken = 1'b0;
  int          gap = 0;
  bit          quiet = 1'b0;
  int          errors = 0;
  int          n_results = 0;
  int          n_placed = 0;
  int          n_full = 0;
  int          n_cfg = 0;

  // Shadow copy of the segment table
  logic [15:0] own_tab[NSEG];
  logic [15:0] len_tab[NSEG];
  int          seg_count;
  logic [1:0]  fit_rule;
  logic [15:0] mem_total;

  segment_fit_allocator #(.MAX_SEGMENTS(NSEG)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode),
    .owner_id(owner_id), .request_size(request_size), .done(done), .status(status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic void restart_table();
    for (int i = 0; i < NSEG; i++) begin
      own_tab[i] = '0;
      len_tab[i] = '0;
    end
    len_tab[0] = mem_total;
    seg_count = 1;
  endfunction

  function automatic logic [2:0] place_segment(input logic [15:0] id, input logic [15:0] sz);
    int pick;
    bit found;
    pick = 0;
    found = 1'b0;
    if (fit_rule > FIT_WORST) return ST_NOFIT;
    for (int i = 0; i < seg_count; i++) begin
      if (own_tab[i] != 0 || len_tab[i] < sz) continue;
      if (!found) begin
        pick = i;
        found = 1'b1;
        if (fit_rule == FIT_FIRST) break;
      end else if (fit_rule == FIT_BEST && len_tab[i] < len_tab[pick]) begin
        pick = i;
      end else if (fit_rule == FIT_WORST && len_tab[i] > len_tab[pick]) begin
        pick = i;
      end
    end
    if (!found) return ST_NOFIT;
    // Split off the remainder just behind the pick
    if (len_tab[pick] > sz) begin
      if (seg_count >= NSEG) return ST_FULL;
      for (int i = seg_count; i > pick + 1; i--) begin
        own_tab[i] = own_tab[i-1];
        len_tab[i] = len_tab[i-1];
      end
      own_tab[pick+1] = '0;
      len_tab[pick+1] = len_tab[pick] - sz;
      len_tab[pick] = sz;
      seg_count++;
    end
    own_tab[pick] = id;
    return ST_DONE;
  endfunction

  function automatic logic [2:0] free_owner(input logic [15:0] id);
    bit found;
    int w;
    found = 1'b0;
    w = 0;
    for (int i = 0; i < seg_count; i++) begin
      if (own_tab[i] == id) begin
        own_tab[i] = '0;
        found = 1'b1;
      end
    end
    // Coalesce runs of free segments
    for (int r = 0; r < seg_count; r++) begin
      if (w > 0 && own_tab[w-1] == 0 && own_tab[r] == 0) begin
        len_tab[w-1] = len_tab[w-1] + len_tab[r];
      end else begin
        own_tab[w] = own_tab[r];
        len_tab[w] = len_tab[r];
        w++;
      end
    end
    for (int r = w; r < NSEG; r++) begin
      own_tab[r] = '0;
      len_tab[r] = '0;
    end
    seg_count = w;
    return found ? ST_DONE : ST_NOTFOUND;
  endfunction

  function automatic logic [2:0] predict_status(input logic md, input logic [15:0] id,
                                                input logic [15:0] sz);
    if (id == 0) return ST_BAD;
    if (md == MODE_ALLOC) return (sz == 0) ? ST_BAD : place_segment(id, sz);
    return free_owner(id);
  endfunction

  task automatic report(input string what, input logic [2:0] got, input logic [2:0] want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  task automatic add_req(input logic md, input logic [15:0] id, input logic [15:0] sz);
    item_t it;
    it = '{kind: K_REQ, mode: md, id: id, size: sz, idx: '0, data: '0};
    pending.push_back(it);
  endtask

  task automatic add_cfg(input logic [7:0] idx, input logic [15:0] data);
    item_t it;
    it = '{kind: K_CFG, mode: MODE_ALLOC, id: '0, size: '0, idx: idx, data: data};
    pending.push_back(it);
  endtask

  task automatic add_pause();
    item_t it;
    it = '{kind: K_PAUSE, mode: MODE_ALLOC, id: '0, size: '0, idx: '0, data: '0};
    pending.push_back(it);
  endtask

  // Monitor: takes requests, config writes and results at the rising edge
  always @(posedge clk) begin
    logic [2:0] want;
    if (rst) begin
      fit_rule = FIT_FIRST;
      mem_total = DEFAULT_TOTAL;
      restart_table();
      req_taken <= 1'b0;
      cfg_taken <= 1'b0;
    end else begin
      if (done) begin
        n_results++;
        if (status_due.size() == 0) begin
          report("result with none due", status, 3'd0);
        end else begin
          want = status_due.pop_front();
          if (status !== want) report("status", status, want);
        end
      end
      req_taken <= start && !busy;
      cfg_taken <= cfg_valid && cfg_ready;
      if (start && !busy) begin
        want = predict_status(mode, owner_id, request_size);
        if (mode == MODE_ALLOC && want == ST_DONE) n_placed++;
        if (want == ST_FULL) n_full++;
        status_due.push_back(want);
      end
      if (cfg_valid && cfg_ready) begin
        n_cfg++;
        if (cfg_index == REG_STRATEGY) begin
          fit_rule = cfg_data[1:0];
        end else if (cfg_index == REG_TOTAL) begin
          mem_total = cfg_data;
          restart_table();
        end
      end
    end
  end

  // Driver: changes inputs at the falling edge, fed from the pending queue
  always @(negedge clk) begin
    logic  nxt_start;
    logic  nxt_cfg;
    item_t it;
    if (!rst) begin
      nxt_start = start;
      nxt_cfg = cfg_valid;
      if (start && req_taken) nxt_start = 1'b0;
      if (cfg_valid && cfg_taken) nxt_cfg = 1'b0;
      if ($urandom_range(0, 39) == 0) quiet = !quiet;
      if (!nxt_start && !nxt_cfg) begin
        if (gap > 0) begin
          gap--;
        end else if (pending.size() > 0) begin
          it = pending[0];
          case (it.kind)
            K_REQ: begin
              void'(pending.pop_front());
              nxt_start = 1'b1;
              mode <= it.mode;
              owner_id <= it.id;
              request_size <= it.size;
              gap = quiet ? 0 : $urandom_range(0, 11);
            end
            K_CFG: begin
              if (status_due.size() == 0 && !start) begin
                void'(pending.pop_front());
                nxt_cfg = 1'b1;
                cfg_index <= it.idx;
                cfg_data <= it.data;
              end
            end
            default: begin
              // hold off until the block has drained
              if (status_due.size() == 0 && !start) begin
                void'(pending.pop_front());
                gap = $urandom_range(5, 40);
              end
            end
          endcase
        end
      end
      start <= nxt_start;
      cfg_valid <= nxt_cfg;
    end
  end

  // Stimulus
  initial begin
    int          n_phase;
    int          span;
    logic [15:0] tot;
    logic [15:0] id;
    logic [15:0] sz;
    int          r;

    // Directed: reset defaults, reserved id, empty request, exact fit, misses
    add_req(MODE_ALLOC, 16'd1, 16'd100);
    add_req(MODE_ALLOC, 16'd0, 16'd10);
    add_req(MODE_RELEASE, 16'd0, 16'd0);
    add_req(MODE_ALLOC, 16'd2, 16'd0);
    add_req(MODE_ALLOC, 16'd3, 16'hFFFF);
    add_req(MODE_RELEASE, 16'hFFFF, 16'hFFFF);
    add_req(MODE_ALLOC, 16'd1, 16'd50);
    add_req(MODE_ALLOC, 16'hFFFF, 16'd3850);
    add_req(MODE_ALLOC, 16'd4, 16'd1);
    add_req(MODE_RELEASE, 16'd1, 16'd0);
    add_req(MODE_RELEASE, 16'hFFFF, 16'd0);
    add_cfg(REG_STRATEGY, 16'hFFFF);
    add_req(MODE_ALLOC, 16'd5, 16'd1);
    add_cfg(8'd7, 16'd9);
    add_cfg(REG_TOTAL, 16'd0);
    add_req(MODE_ALLOC, 16'd6, 16'd1);
    add_cfg(REG_STRATEGY, {14'd0, FIT_BEST});
    add_cfg(REG_TOTAL, 16'hFFFF);
    add_req(MODE_ALLOC, 16'd7, 16'd10);
    add_req(MODE_ALLOC, 16'd8, 16'd20);
    add_req(MODE_RELEASE, 16'd7, 16'd0);
    add_req(MODE_ALLOC, 16'd9, 16'd5);
    add_cfg(REG_STRATEGY, {14'd0, FIT_WORST});
    add_req(MODE_ALLOC, 16'd10, 16'd5);

    // Random phases with a fresh table and rule each time
    for (n_phase = 0; n_phase < 16; n_phase++) begin
      r = $urandom_range(0, 5);
      tot = (r == 0) ? 16'd1 : (r == 1) ? 16'd64 : (r == 2) ? 16'd500 :
            (r == 3) ? 16'd4000 : (r == 4) ? 16'hFFFF : 16'($urandom_range(1, 65535));
      add_cfg(REG_STRATEGY, (n_phase == 5) ? 16'd3 : 16'($urandom_range(0, 2)));
      add_cfg(REG_TOTAL, tot);
      span = (tot / 48 > 1) ? tot / 48 : 2;
      if (n_phase == 8) add_pause();
      for (int k = 0; k < 100; k++) begin
        r = $urandom_range(0, 99);
        id = 16'($urandom_range(1, 12));
        sz = 16'($urandom_range(1, span));
        if (r < 5) begin
          add_req(1'($urandom), 16'($urandom), 16'($urandom));
        end else if (r < 8) begin
          add_req(1'($urandom), 16'd0, sz);
        end else if (r < 10) begin
          add_req(MODE_ALLOC, id, 16'd0);
        end else if (r < 72) begin
          add_req(MODE_ALLOC, id, sz);
        end else begin
          add_req(MODE_RELEASE, id, 16'($urandom));
        end
      end
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    wait (pending.size() == 0 && !start && !cfg_valid && status_due.size() == 0);
    repeat (2 * NSEG + 20) @(posedge clk);
    $display("%0d results checked, %0d config writes, %0d placements, %0d table-full answers",
             n_results, n_cfg, n_placed, n_full);
    if (errors == 0 && status_due.size() == 0) begin
      $display("segment_fit_allocator_tb passed");
    end else begin
      $display("segment_fit_allocator_tb failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("segment_fit_allocator_tb failed");
    $finish;
  end

endmodule
